// ----- sv/priority_round_robin_scheduler_defines.svh -----
// Assertion macros
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PRRS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: implication failed");
`define PRRS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: next-cycle check failed");
`endif

// ----- sv/prrs_pkg.sv -----
package prrs_pkg;
  localparam int NumThreads = 16;
  localparam int NumLevels  = 8;
  localparam int TidW = $clog2(NumThreads);
  localparam int LvW  = $clog2(NumLevels);
  localparam int SlotW = $clog2(NumThreads + 1);
  localparam logic [SlotW-1:0] Nil = SlotW'(NumThreads);

  localparam logic [2:0] CmdEnq   = 3'd0;
  localparam logic [2:0] CmdKill  = 3'd1;
  localparam logic [2:0] CmdBlock = 3'd2;
  localparam logic [2:0] CmdPre   = 3'd3;
  localparam logic [2:0] CmdPick  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNotFnd  = 2'd1;
  localparam logic [1:0] StRunning = 2'd2;
  localparam logic [1:0] StNoReady = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_WALK, S_APPEND, S_PICK, S_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture input item
    logic decode;    // evaluate command, set target
    logic walk_step; // one list step
    logic append;
    logic pick_step; // one level step
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic need_walk;
    logic need_append;
    logic need_pick;
    logic walk_done;
    logic pick_done;
  } sts_t;
endpackage

// ----- sv/prrs_datapath.sv -----
module prrs_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  prrs_pkg::cmd_t   ctl_i,
  output prrs_pkg::sts_t   sts_o,
  input  logic [9:0]       in_data_i,
  output logic [7:0]       out_data_o
);
  localparam int TW = prrs_pkg::TidW;
  localparam int LW = prrs_pkg::LvW;
  localparam int SW = prrs_pkg::SlotW;
  localparam int NT = prrs_pkg::NumThreads;
  localparam int NL = prrs_pkg::NumLevels;

  logic [NT-1:0]         queued_q;
  logic [LW-1:0]         level_q [NT];
  logic [SW-1:0]         link_q [NT];
  logic [SW-1:0]         head_q [NL];
  logic [SW-1:0]         tail_q [NL];
  logic [TW-1:0]         run_q;
  logic                  runv_q;

  logic [2:0]    cmd_q;
  logic [3:0]    tid_q;
  logic [2:0]    pri_q;
  logic [TW-1:0] tgt_q;
  logic [LW-1:0] alv_q;
  logic [LW-1:0] wlv_q;
  logic [SW-1:0] prev_q, cur_q;
  logic [SW-1:0] steps_q;
  logic [LW:0]   plv_q;
  logic          nwalk_q, napp_q, npick_q, found_q;
  logic [1:0]    st_q;
  logic [3:0]    nt_q;
  logic          nv_q, sw_q;

  logic [LW-1:0] pri_sat;
  logic          tid_ok;
  logic [TW-1:0] tid_t;
  logic          cur_hit;
  logic [SW-1:0] tgt_link;
  logic [SW-1:0] ph;

  always_comb begin
    pri_sat = (32'(pri_q) >= NL) ? LW'(NL - 1) : LW'(pri_q);
    tid_ok  = 32'(tid_q) < NT;
    tid_t   = TW'(tid_q);
    cur_hit = (cur_q == {1'b0, tgt_q});
    tgt_link = link_q[tgt_q];
    ph = head_q[plv_q[LW-1:0]];
  end

  assign sts_o.need_walk   = nwalk_q;
  assign sts_o.need_append = napp_q;
  assign sts_o.need_pick   = npick_q;
  assign sts_o.walk_done   = found_q || cur_q >= prrs_pkg::Nil || steps_q >= SW'(NT);
  assign sts_o.pick_done   = found_q || plv_q == (LW+1)'(NL);
  assign out_data_o = {sw_q, nv_q, nt_q, st_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      runv_q   <= 1'b0;
      run_q    <= '0;
      for (int i = 0; i < NT; i++) level_q[i] <= '0;
      for (int i = 0; i < NL; i++) begin
        head_q[i] <= prrs_pkg::Nil;
        tail_q[i] <= prrs_pkg::Nil;
      end
    end else begin
      if (ctl_i.walk_step && !found_q && cur_q < prrs_pkg::Nil && cur_hit) begin
        if (prev_q == prrs_pkg::Nil) head_q[wlv_q] <= tgt_link;
        else link_q[prev_q[TW-1:0]] <= tgt_link;
        if (tail_q[wlv_q] == {1'b0, tgt_q}) tail_q[wlv_q] <= prev_q;
      end
      if (ctl_i.walk_step && sts_o.walk_done) begin
        queued_q[tgt_q] <= 1'b0;
        link_q[tgt_q]   <= prrs_pkg::Nil;
      end
      if (ctl_i.append) begin
        link_q[tgt_q] <= prrs_pkg::Nil;
        if (head_q[alv_q] >= prrs_pkg::Nil) head_q[alv_q] <= {1'b0, tgt_q};
        else if (tail_q[alv_q] < prrs_pkg::Nil) link_q[tail_q[alv_q][TW-1:0]] <= {1'b0, tgt_q};
        tail_q[alv_q]   <= {1'b0, tgt_q};
        queued_q[tgt_q] <= 1'b1;
        level_q[tgt_q]  <= alv_q;
      end
      if (ctl_i.pick_step && !found_q && plv_q != (LW+1)'(NL) && ph < prrs_pkg::Nil) begin
        run_q  <= ph[TW-1:0];
        runv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= in_data_i[2:0];
      tid_q <= in_data_i[6:3];
      pri_q <= in_data_i[9:7];
    end
    if (ctl_i.decode) begin
      st_q <= prrs_pkg::StOk; nt_q <= '0; nv_q <= 1'b0; sw_q <= 1'b0;
      nwalk_q <= 1'b0; napp_q <= 1'b0; npick_q <= 1'b0;
      found_q <= 1'b0; steps_q <= '0; prev_q <= prrs_pkg::Nil;
      plv_q <= '0;
      unique case (cmd_q) inside
        prrs_pkg::CmdEnq: begin
          if (!tid_ok) st_q <= prrs_pkg::StNotFnd;
          else begin
            tgt_q <= tid_t; alv_q <= pri_sat; wlv_q <= level_q[tid_t];
            cur_q <= head_q[level_q[tid_t]];
            nwalk_q <= queued_q[tid_t]; napp_q <= 1'b1;
          end
        end
        prrs_pkg::CmdKill: begin
          if (runv_q && {1'b0, run_q} == {1'b0, tid_q}) st_q <= prrs_pkg::StRunning;
          else if (!tid_ok || !queued_q[tid_t]) st_q <= prrs_pkg::StNotFnd;
          else begin
            tgt_q <= tid_t; wlv_q <= level_q[tid_t];
            cur_q <= head_q[level_q[tid_t]]; nwalk_q <= 1'b1;
          end
        end
        prrs_pkg::CmdBlock: begin
          if (!runv_q || !queued_q[run_q]) st_q <= prrs_pkg::StNotFnd;
          else begin
            tgt_q <= run_q; wlv_q <= level_q[run_q];
            cur_q <= head_q[level_q[run_q]]; nwalk_q <= 1'b1;
          end
        end
        prrs_pkg::CmdPre, prrs_pkg::CmdPick: begin
          npick_q <= 1'b1;
          if (cmd_q == prrs_pkg::CmdPre && runv_q && queued_q[run_q]) begin
            tgt_q <= run_q; wlv_q <= level_q[run_q]; alv_q <= level_q[run_q];
            cur_q <= head_q[level_q[run_q]]; nwalk_q <= 1'b1; napp_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ctl_i.walk_step) begin
      if (sts_o.walk_done) found_q <= 1'b0;
      else begin
        if (cur_hit) found_q <= 1'b1;
        prev_q  <= cur_q;
        cur_q   <= link_q[cur_q[TW-1:0]];
        steps_q <= steps_q + 1'b1;
      end
    end
    if (ctl_i.pick_step && !sts_o.pick_done) begin
      if (ph < prrs_pkg::Nil) begin
        found_q <= 1'b1;
        nt_q <= 4'(ph[TW-1:0]); nv_q <= 1'b1;
        sw_q <= !runv_q || run_q != ph[TW-1:0];
      end else begin
        plv_q <= plv_q + 1'b1;
        if (plv_q == (LW+1)'(NL - 1)) begin
          if (runv_q && level_q[run_q] == LW'(NL - 1)) begin
            nt_q <= 4'(run_q); nv_q <= 1'b1;
          end else st_q <= prrs_pkg::StNoReady;
        end
      end
    end
  end
endmodule

// ----- sv/prrs_ctrl.sv -----
module prrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  prrs_pkg::sts_t sts_i,
  output prrs_pkg::cmd_t ctl_o
);
  prrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= prrs_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      prrs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = prrs_pkg::S_DECODE;
        end
      end
      prrs_pkg::S_DECODE: begin
        ctl_o.decode = 1'b1;
        state_d = prrs_pkg::S_WALK;
      end
      prrs_pkg::S_WALK: begin
        if (!sts_i.need_walk) state_d = prrs_pkg::S_APPEND;
        else begin
          ctl_o.walk_step = 1'b1;
          if (sts_i.walk_done) state_d = prrs_pkg::S_APPEND;
        end
      end
      prrs_pkg::S_APPEND: begin
        ctl_o.append = sts_i.need_append;
        state_d = sts_i.need_pick ? prrs_pkg::S_PICK : prrs_pkg::S_OUT;
      end
      prrs_pkg::S_PICK: begin
        ctl_o.pick_step = 1'b1;
        if (sts_i.pick_done) state_d = prrs_pkg::S_OUT;
      end
      prrs_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = prrs_pkg::S_IDLE;
      end
      default: state_d = prrs_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- sv/priority_round_robin_scheduler.sv -----
// Multilevel priority ready-queue scheduler, one linked FIFO per level, level 0
// highest and the last level idle. One item at a time: accept, decode, then a list
// walk when a thread is unlinked, an append step, and a level scan for pick commands,
// then the result holds until taken. The walk and the scan set the worst case from
// one accepted item to the next.
module priority_round_robin_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [15:0] s_axis_tdata, // command[2:0], thread_id[6:3], priority_req[9:7]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // status[1:0], next_thread[5:2], next_valid[6], switched[7]
);
  prrs_pkg::cmd_t ctl;
  prrs_pkg::sts_t sts;

  prrs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .ctl_o(ctl)
  );

  prrs_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .in_data_i(s_axis_tdata[9:0]), .out_data_o(m_axis_tdata)
  );
endmodule

// ----- sv/prrs_checker.sv -----
`include "priority_round_robin_scheduler_defines.svh"
module prrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  `PRRS_ASSERT_IMP(a_excl, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `PRRS_ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PRRS_ASSERT_IMP(a_nv, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[6], m_axis_tdata[7:2] == 6'd0)
  `PRRS_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule

bind priority_round_robin_scheduler prrs_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ----- verif/priority_round_robin_scheduler_test.sv -----
module priority_round_robin_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       switched;
    logic       next_valid;
    logic [3:0] next_thread;
    logic [1:0] status;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  priority_round_robin_scheduler i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // scheduler shadow state
  logic                       q_flag [prrs_pkg::NumThreads];
  logic [prrs_pkg::LvW-1:0]   t_lvl  [prrs_pkg::NumThreads];
  logic [prrs_pkg::SlotW-1:0] nxt    [prrs_pkg::NumThreads];
  logic [prrs_pkg::SlotW-1:0] head   [prrs_pkg::NumLevels];
  logic [prrs_pkg::SlotW-1:0] tail   [prrs_pkg::NumLevels];
  logic [prrs_pkg::TidW-1:0]  run_tid;
  logic                       run_vld;

  sched_res_t expected_q[$];
  int  errors = 0;
  bit  gaps_on = 1'b1;
  bit  hold_rx = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic void sched_reset();
    for (int i = 0; i < prrs_pkg::NumThreads; i++) begin
      q_flag[i] = 0; t_lvl[i] = 0; nxt[i] = prrs_pkg::Nil;
    end
    for (int i = 0; i < prrs_pkg::NumLevels; i++) begin
      head[i] = prrs_pkg::Nil; tail[i] = prrs_pkg::Nil;
    end
    run_tid = 0; run_vld = 0;
  endfunction

  function automatic void unlink(input int t);
    int lv;
    int prev;
    int cur;
    lv = t_lvl[t];
    prev = prrs_pkg::NumThreads;
    cur = head[lv];
    for (int s = 0; s < prrs_pkg::NumThreads && cur < prrs_pkg::NumThreads; s++) begin
      if (cur == t) begin
        if (prev == prrs_pkg::NumThreads) head[lv] = nxt[t];
        else nxt[prev] = nxt[t];
        if (tail[lv] == t) tail[lv] = prrs_pkg::SlotW'(prev);
        break;
      end
      prev = cur;
      cur = nxt[cur];
    end
    q_flag[t] = 0;
    nxt[t] = prrs_pkg::Nil;
  endfunction

  function automatic void append(input int t, input int lv);
    nxt[t] = prrs_pkg::Nil;
    if (head[lv] >= prrs_pkg::NumThreads) head[lv] = prrs_pkg::SlotW'(t);
    else if (tail[lv] < prrs_pkg::NumThreads) nxt[tail[lv]] = prrs_pkg::SlotW'(t);
    tail[lv] = prrs_pkg::SlotW'(t);
    q_flag[t] = 1;
    t_lvl[t] = prrs_pkg::LvW'(lv);
  endfunction

  function automatic sched_res_t pick();
    sched_res_t r;
    r = '0;
    for (int lv = 0; lv < prrs_pkg::NumLevels; lv++) begin
      if (head[lv] < prrs_pkg::NumThreads) begin
        r.next_thread = prrs_pkg::TidW'(head[lv]);
        r.next_valid = 1;
        r.switched = (!run_vld || run_tid != prrs_pkg::TidW'(head[lv]));
        run_tid = prrs_pkg::TidW'(head[lv]);
        run_vld = 1;
        return r;
      end
    end
    if (run_vld && t_lvl[run_tid] == prrs_pkg::NumLevels - 1) begin
      r.next_thread = run_tid;
      r.next_valid = 1;
      return r;
    end
    r.status = prrs_pkg::StNoReady;
    return r;
  endfunction

  function automatic sched_res_t schedule(input logic [2:0] cmd, input int tid,
                                          input int lv);
    sched_res_t r;
    int rl;
    r = '0;
    case (cmd)
      prrs_pkg::CmdEnq: begin
        if (q_flag[tid]) unlink(tid);
        append(tid, lv);
      end
      prrs_pkg::CmdKill: begin
        if (run_vld && run_tid == tid) r.status = prrs_pkg::StRunning;
        else if (!q_flag[tid]) r.status = prrs_pkg::StNotFnd;
        else unlink(tid);
      end
      prrs_pkg::CmdBlock: begin
        if (!run_vld || !q_flag[run_tid]) r.status = prrs_pkg::StNotFnd;
        else unlink(run_tid);
      end
      prrs_pkg::CmdPre: begin
        if (run_vld && q_flag[run_tid]) begin
          rl = t_lvl[run_tid];
          unlink(run_tid);
          append(run_tid, rl);
        end
        r = pick();
      end
      prrs_pkg::CmdPick: r = pick();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input int tid, input int lv);
    bit idle;
    idle = gaps_on && ($urandom_range(99) < 27);
    if (idle) begin
      s_axis_tvalid <= 1'b0;
      while (idle) begin
        @(posedge clk_i);
        idle = gaps_on && ($urandom_range(99) < 27);
      end
    end
    s_axis_tdata <= {6'd0, 3'(lv), 4'(tid), cmd};
    s_axis_tvalid <= 1'b1;
    expected_q.push_back(schedule(cmd, tid, lv));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= !gaps_on || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    sched_res_t got;
    sched_res_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        exp = expected_q.pop_front();
        if (got.status != exp.status)
          report($sformatf("status %0d exp %0d", got.status, exp.status));
        if (got.next_thread != exp.next_thread)
          report($sformatf("next_thread %0d exp %0d", got.next_thread, exp.next_thread));
        if (got.next_valid != exp.next_valid)
          report($sformatf("next_valid %0d exp %0d", got.next_valid, exp.next_valid));
        if (got.switched != exp.switched)
          report($sformatf("switched %0d exp %0d", got.switched, exp.switched));
      end
    end
  end

  task automatic test_directed();
    send_item(prrs_pkg::CmdPick, 0, 0);
    send_item(prrs_pkg::CmdBlock, 0, 0);
    send_item(prrs_pkg::CmdKill, 15, 0);
    send_item(prrs_pkg::CmdPre, 0, 0);
    send_item(prrs_pkg::CmdEnq, 15, 7);
    send_item(prrs_pkg::CmdPick, 0, 0);
    send_item(prrs_pkg::CmdBlock, 0, 0);
    send_item(prrs_pkg::CmdPick, 0, 0);
    send_item(prrs_pkg::CmdBlock, 0, 0);
    send_item(prrs_pkg::CmdKill, 15, 0);
    send_item(prrs_pkg::CmdEnq, 0, 0);
    send_item(prrs_pkg::CmdEnq, 5, 0);
    send_item(prrs_pkg::CmdEnq, 9, 3);
    send_item(prrs_pkg::CmdEnq, 0, 3);
    send_item(prrs_pkg::CmdPick, 3, 5);
    send_item(prrs_pkg::CmdPre, 0, 0);
    send_item(prrs_pkg::CmdKill, 5, 0);
    send_item(prrs_pkg::CmdKill, 9, 0);
    send_item(prrs_pkg::CmdKill, 0, 0);
    send_item(prrs_pkg::CmdPre, 0, 0);
    send_item(3'd5, 15, 7);
    send_item(3'd6, 1, 1);
    send_item(3'd7, 8, 4);
    send_item(prrs_pkg::CmdBlock, 0, 0);
    send_item(prrs_pkg::CmdPick, 0, 0);
  endtask

  task automatic test_random(input int n);
    int k;
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 40) cmd = prrs_pkg::CmdEnq;
      else if (k < 55) cmd = prrs_pkg::CmdKill;
      else if (k < 67) cmd = prrs_pkg::CmdBlock;
      else if (k < 82) cmd = prrs_pkg::CmdPre;
      else if (k < 96) cmd = prrs_pkg::CmdPick;
      else cmd = 3'($urandom_range(7, 5));
      send_item(cmd, $urandom_range(15), $urandom_range(7));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      test_random(40);
    join
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    test_random(300);
    gaps_on = 1'b1;
  endtask

  initial begin
    int wait_cnt;
    sched_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    test_backpressure();
    test_no_gaps();
    test_random(450);
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ----- priority_round_robin_scheduler.f -----
+incdir+sv
sv/prrs_pkg.sv
sv/prrs_datapath.sv
sv/prrs_ctrl.sv
sv/priority_round_robin_scheduler.sv
sv/prrs_checker.sv
verif/priority_round_robin_scheduler_test.sv
